// ===== src/dcdw_pkg.sv =====
// Package for the drive command decoder with idle watchdog.
// Holds the drive mode type, command characters, pin patterns and reset values.
// No dependencies.
package dcdw_pkg;

  // Drive modes as seen on drive_mode_o
  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4
  } drive_mode_e;

  // Configuration register indexes (byte address 4*index)
  localparam logic [1:0] REG_DRIVE_SPEED = 2'd0;
  localparam logic [1:0] REG_FAN_SPEED   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_MS  = 2'd2;

  // Command characters
  localparam logic [7:0] CMD_FWD       = 8'h77; // w
  localparam logic [7:0] CMD_BACK      = 8'h73; // s
  localparam logic [7:0] CMD_LEFT      = 8'h6C; // l
  localparam logic [7:0] CMD_RIGHT     = 8'h72; // r
  localparam logic [7:0] CMD_STOP      = 8'h71; // q
  localparam logic [7:0] CMD_FAN_ON    = 8'h61; // a
  localparam logic [7:0] CMD_FAN_OFF   = 8'h64; // d
  localparam logic [7:0] CMD_HAND_OPEN = 8'h74; // t
  localparam logic [7:0] CMD_HAND_SHUT = 8'h67; // g
  localparam logic [7:0] CMD_ARM_HOME  = 8'h7A; // z
  localparam logic [7:0] CMD_ARM_UP    = 8'h70; // p
  localparam logic [7:0] CMD_ARM_DOWN  = 8'h62; // b
  localparam logic [7:0] CMD_BASE_LO   = 8'h63; // c
  localparam logic [7:0] CMD_BASE_HI   = 8'h76; // v
  localparam logic [7:0] CMD_CLAW_SHUT = 8'h65; // e
  localparam logic [7:0] CMD_CLAW_OPEN = 8'h66; // f

  // Bridge direction patterns, bits 5..0 = A1,A2,B1,B2,C1,C2
  localparam logic [5:0] PINS_FWD   = 6'b010100;
  localparam logic [5:0] PINS_BACK  = 6'b101000;
  localparam logic [5:0] PINS_LEFT  = 6'b100110;
  localparam logic [5:0] PINS_RIGHT = 6'b011001;

  // Servo angles in degrees
  localparam logic [7:0] ANG_30  = 8'd30;
  localparam logic [7:0] ANG_50  = 8'd50;
  localparam logic [7:0] ANG_55  = 8'd55;
  localparam logic [7:0] ANG_90  = 8'd90;
  localparam logic [7:0] ANG_95  = 8'd95;
  localparam logic [7:0] ANG_150 = 8'd150;
  localparam logic [7:0] ANG_160 = 8'd160;
  localparam logic [7:0] ANG_180 = 8'd180;

  // Register reset values and the idle counter limit
  localparam logic [7:0]  DRIVE_SPEED_RST = 8'd180;
  localparam logic [7:0]  FAN_SPEED_RST   = 8'd180;
  localparam logic [15:0] TIMEOUT_MS_RST  = 16'd5000;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

endpackage

// ===== src/drive_command_decoder_watchdog_unit.sv =====
// Drive command decoder with idle watchdog: top level.
// Decodes command bytes and millisecond ticks into bridge pins, duties and servo angles.
// Depends on dcdw_pkg.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid_i/in_ready_o, req_type_i,   | in
//            | cmd_byte_i                           |
//   result   | out_valid_o/out_ready_i, dir_pins_o, | out
//            | drive_duty_o .. safety_stop_o        |
//   config   | APB psel/penable/pwrite/paddr/pwdata | in/out
//
// One transaction per cycle while out_ready_i is high; each passes the input
// register, then the decode and watchdog update into the result register.
// rst_ni clears the pipeline valids and loads the documented reset state.
// A stalled result holds; the input register keeps taking transactions as
// long as the result register can drain, so a full stall costs no bubble.
module drive_command_decoder_watchdog_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  cmd_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  dir_pins_o,
  output logic [7:0]  drive_duty_o,
  output logic [7:0]  fan_duty_o,
  output logic [7:0]  hand_angle_o,
  output logic [7:0]  wrist_angle_o,
  output logic [7:0]  elbow_angle_o,
  output logic [7:0]  base_angle_o,
  output logic [7:0]  claw_angle_o,
  output logic [2:0]  drive_mode_o,
  output logic        safety_stop_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [7:0]  drive_speed_q;
  logic [7:0]  fan_speed_q;
  logic [15:0] timeout_ms_q;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_speed_q <= dcdw_pkg::DRIVE_SPEED_RST;
      fan_speed_q   <= dcdw_pkg::FAN_SPEED_RST;
      timeout_ms_q  <= dcdw_pkg::TIMEOUT_MS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        dcdw_pkg::REG_DRIVE_SPEED: drive_speed_q <= pwdata[7:0];
        dcdw_pkg::REG_FAN_SPEED:   fan_speed_q   <= pwdata[7:0];
        dcdw_pkg::REG_TIMEOUT_MS:  timeout_ms_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_idx)
      dcdw_pkg::REG_DRIVE_SPEED: prdata = {24'd0, drive_speed_q};
      dcdw_pkg::REG_FAN_SPEED:   prdata = {24'd0, fan_speed_q};
      dcdw_pkg::REG_TIMEOUT_MS:  prdata = {16'd0, timeout_ms_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // Pipeline handshake
  logic in_vld_q;
  logic req_type_q;
  logic [7:0] cmd_byte_q;
  logic out_vld_q;
  logic out_free;
  logic advance;

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q <= req_type_i;
      cmd_byte_q <= cmd_byte_i;
    end
  end

  // Block state
  dcdw_pkg::drive_mode_e mode_q, mode_d;
  logic [5:0]  pins_q, pins_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  fan_q, fan_d;
  logic [7:0]  hand_q, hand_d, wrist_q, wrist_d, elbow_q, elbow_d;
  logic [7:0]  base_q, base_d, claw_q, claw_d;
  logic        flag_d;
  logic [7:0]  duty_d;

  // Byte decode and idle counter
  always_comb begin
    mode_d  = mode_q;
    fan_d   = fan_q;
    hand_d  = hand_q;
    wrist_d = wrist_q;
    elbow_d = elbow_q;
    base_d  = base_q;
    claw_d  = claw_q;
    idle_d  = idle_q;
    flag_d  = 1'b0;
    if (!req_type_q) begin
      idle_d = 16'd0;
      unique case (cmd_byte_q)
        dcdw_pkg::CMD_FWD:       mode_d = dcdw_pkg::MODE_FWD;
        dcdw_pkg::CMD_BACK:      mode_d = dcdw_pkg::MODE_BACK;
        dcdw_pkg::CMD_LEFT:      mode_d = dcdw_pkg::MODE_LEFT;
        dcdw_pkg::CMD_RIGHT:     mode_d = dcdw_pkg::MODE_RIGHT;
        dcdw_pkg::CMD_STOP:      mode_d = dcdw_pkg::MODE_STOP;
        dcdw_pkg::CMD_FAN_ON:    fan_d  = fan_speed_q;
        dcdw_pkg::CMD_FAN_OFF:   fan_d  = 8'd0;
        dcdw_pkg::CMD_HAND_OPEN: hand_d = dcdw_pkg::ANG_50;
        dcdw_pkg::CMD_HAND_SHUT: hand_d = dcdw_pkg::ANG_180;
        dcdw_pkg::CMD_ARM_HOME: begin
          hand_d  = dcdw_pkg::ANG_50;
          wrist_d = dcdw_pkg::ANG_90;
          elbow_d = dcdw_pkg::ANG_90;
          base_d  = dcdw_pkg::ANG_90;
        end
        dcdw_pkg::CMD_ARM_UP: begin
          wrist_d = dcdw_pkg::ANG_30;
          elbow_d = dcdw_pkg::ANG_180;
        end
        dcdw_pkg::CMD_ARM_DOWN: begin
          wrist_d = dcdw_pkg::ANG_180;
          elbow_d = dcdw_pkg::ANG_55;
        end
        dcdw_pkg::CMD_BASE_LO:   base_d = dcdw_pkg::ANG_30;
        dcdw_pkg::CMD_BASE_HI:   base_d = dcdw_pkg::ANG_150;
        dcdw_pkg::CMD_CLAW_SHUT: claw_d = dcdw_pkg::ANG_160;
        dcdw_pkg::CMD_CLAW_OPEN: claw_d = dcdw_pkg::ANG_95;
        default: ;
      endcase
    end else if (idle_q != dcdw_pkg::IDLE_MAX) begin
      idle_d = idle_q + 16'd1;
    end

    // Watchdog: force stop once idle time exceeds the timeout
    if (idle_d > timeout_ms_q && mode_d != dcdw_pkg::MODE_STOP) begin
      mode_d = dcdw_pkg::MODE_STOP;
      flag_d = 1'b1;
    end
  end

  // Bridge pins and drive duty from the updated mode; stop keeps the pins
  always_comb begin
    pins_d = pins_q;
    duty_d = drive_speed_q;
    unique case (mode_d)
      dcdw_pkg::MODE_FWD:   pins_d = dcdw_pkg::PINS_FWD;
      dcdw_pkg::MODE_BACK:  pins_d = dcdw_pkg::PINS_BACK;
      dcdw_pkg::MODE_LEFT:  pins_d = dcdw_pkg::PINS_LEFT;
      dcdw_pkg::MODE_RIGHT: pins_d = dcdw_pkg::PINS_RIGHT;
      default:              duty_d = 8'd0;
    endcase
  end

  // State update on each transaction moving into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= dcdw_pkg::MODE_STOP;
      pins_q  <= 6'd0;
      idle_q  <= 16'd0;
      fan_q   <= 8'd0;
      hand_q  <= dcdw_pkg::ANG_50;
      wrist_q <= dcdw_pkg::ANG_90;
      elbow_q <= dcdw_pkg::ANG_90;
      base_q  <= dcdw_pkg::ANG_90;
      claw_q  <= dcdw_pkg::ANG_95;
    end else if (advance) begin
      mode_q  <= mode_d;
      pins_q  <= pins_d;
      idle_q  <= idle_d;
      fan_q   <= fan_d;
      hand_q  <= hand_d;
      wrist_q <= wrist_d;
      elbow_q <= elbow_d;
      base_q  <= base_d;
      claw_q  <= claw_d;
    end
  end

  // Result register
  logic [7:0] duty_q;
  logic       flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_q <= duty_d;
      flag_q <= flag_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign dir_pins_o    = pins_q;
  assign drive_duty_o  = duty_q;
  assign fan_duty_o    = fan_q;
  assign hand_angle_o  = hand_q;
  assign wrist_angle_o = wrist_q;
  assign elbow_angle_o = elbow_q;
  assign base_angle_o  = base_q;
  assign claw_angle_o  = claw_q;
  assign drive_mode_o  = mode_q;
  assign safety_stop_o = flag_q;

endmodule

// ===== tb/sv/tb_drive_command_decoder_watchdog_unit.sv =====
// Testbench for drive_command_decoder_watchdog_unit: directed and random command/tick
// traffic with APB register changes, checked against an in-bench decoder/watchdog model.
// Depends on dcdw_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_drive_command_decoder_watchdog_unit;

  // Index past the end of the register map; writes there must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PHASE_COUNT = 9;
  localparam int PHASE_ITEMS = 130;
  localparam int LONG_TIMEOUT_TICKS = 60;

  // Moving commands first so they can be picked on their own
  localparam logic [7:0] COMMAND_SET [16] = '{
    dcdw_pkg::CMD_FWD, dcdw_pkg::CMD_BACK, dcdw_pkg::CMD_LEFT, dcdw_pkg::CMD_RIGHT,
    dcdw_pkg::CMD_STOP, dcdw_pkg::CMD_FAN_ON, dcdw_pkg::CMD_FAN_OFF,
    dcdw_pkg::CMD_HAND_OPEN, dcdw_pkg::CMD_HAND_SHUT, dcdw_pkg::CMD_ARM_HOME,
    dcdw_pkg::CMD_ARM_UP, dcdw_pkg::CMD_ARM_DOWN, dcdw_pkg::CMD_BASE_LO,
    dcdw_pkg::CMD_BASE_HI, dcdw_pkg::CMD_CLAW_SHUT, dcdw_pkg::CMD_CLAW_OPEN
  };

  typedef struct packed {
    logic [5:0]            dir_pins;
    logic [7:0]            drive_duty;
    logic [7:0]            fan_duty;
    logic [7:0]            hand;
    logic [7:0]            wrist;
    logic [7:0]            elbow;
    logic [7:0]            base;
    logic [7:0]            claw;
    dcdw_pkg::drive_mode_e mode;
    logic                  safety_stop;
  } drive_outputs_t;

  // Decoder/watchdog model plus the queue of outputs it still owes
  class drive_scoreboard;
    logic [7:0]            drive_speed;
    logic [7:0]            fan_speed;
    logic [15:0]           timeout_ms;
    dcdw_pkg::drive_mode_e mode;
    logic [5:0]            pins;
    logic [15:0]           idle_ms;
    logic [7:0]            fan;
    logic [7:0]            hand, wrist, elbow, base, claw;
    drive_outputs_t        expected_outputs[$];
    int                    mismatches;
    int                    results_seen;
    string                 field_names[10] = '{"dir_pins", "drive_duty", "fan_duty",
                                               "hand_angle", "wrist_angle", "elbow_angle",
                                               "base_angle", "claw_angle", "drive_mode",
                                               "safety_stop"};

    function new();
      drive_speed = dcdw_pkg::DRIVE_SPEED_RST;
      fan_speed   = dcdw_pkg::FAN_SPEED_RST;
      timeout_ms  = dcdw_pkg::TIMEOUT_MS_RST;
      mode        = dcdw_pkg::MODE_STOP;
      pins        = '0;
      idle_ms     = '0;
      fan         = '0;
      hand        = dcdw_pkg::ANG_50;
      wrist       = dcdw_pkg::ANG_90;
      elbow       = dcdw_pkg::ANG_90;
      base        = dcdw_pkg::ANG_90;
      claw        = dcdw_pkg::ANG_95;
      mismatches  = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] value);
      case (index)
        dcdw_pkg::REG_DRIVE_SPEED: drive_speed = value[7:0];
        dcdw_pkg::REG_FAN_SPEED:   fan_speed   = value[7:0];
        dcdw_pkg::REG_TIMEOUT_MS:  timeout_ms  = value[15:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted transaction and queue the outputs it produces
    function void predict_outputs(logic is_tick, logic [7:0] cmd);
      drive_outputs_t r;
      logic           forced;
      logic [7:0]     duty;
      forced = 1'b0;
      duty   = '0;
      if (!is_tick) begin
        case (cmd)
          dcdw_pkg::CMD_FWD:       mode = dcdw_pkg::MODE_FWD;
          dcdw_pkg::CMD_BACK:      mode = dcdw_pkg::MODE_BACK;
          dcdw_pkg::CMD_LEFT:      mode = dcdw_pkg::MODE_LEFT;
          dcdw_pkg::CMD_RIGHT:     mode = dcdw_pkg::MODE_RIGHT;
          dcdw_pkg::CMD_STOP:      mode = dcdw_pkg::MODE_STOP;
          dcdw_pkg::CMD_FAN_ON:    fan = fan_speed;
          dcdw_pkg::CMD_FAN_OFF:   fan = '0;
          dcdw_pkg::CMD_HAND_OPEN: hand = dcdw_pkg::ANG_50;
          dcdw_pkg::CMD_HAND_SHUT: hand = dcdw_pkg::ANG_180;
          dcdw_pkg::CMD_ARM_HOME: begin
            hand  = dcdw_pkg::ANG_50;
            wrist = dcdw_pkg::ANG_90;
            elbow = dcdw_pkg::ANG_90;
            base  = dcdw_pkg::ANG_90;
          end
          dcdw_pkg::CMD_ARM_UP: begin
            wrist = dcdw_pkg::ANG_30;
            elbow = dcdw_pkg::ANG_180;
          end
          dcdw_pkg::CMD_ARM_DOWN: begin
            wrist = dcdw_pkg::ANG_180;
            elbow = dcdw_pkg::ANG_55;
          end
          dcdw_pkg::CMD_BASE_LO:   base = dcdw_pkg::ANG_30;
          dcdw_pkg::CMD_BASE_HI:   base = dcdw_pkg::ANG_150;
          dcdw_pkg::CMD_CLAW_SHUT: claw = dcdw_pkg::ANG_160;
          dcdw_pkg::CMD_CLAW_OPEN: claw = dcdw_pkg::ANG_95;
          default: ;
        endcase
        idle_ms = '0;
      end else if (idle_ms != dcdw_pkg::IDLE_MAX) begin
        idle_ms = idle_ms + 16'd1;
      end
      // watchdog: only a moving state gets forced to stop
      if (idle_ms > timeout_ms && mode != dcdw_pkg::MODE_STOP) begin
        mode   = dcdw_pkg::MODE_STOP;
        forced = 1'b1;
      end
      case (mode)
        dcdw_pkg::MODE_FWD:   begin pins = dcdw_pkg::PINS_FWD;   duty = drive_speed; end
        dcdw_pkg::MODE_BACK:  begin pins = dcdw_pkg::PINS_BACK;  duty = drive_speed; end
        dcdw_pkg::MODE_LEFT:  begin pins = dcdw_pkg::PINS_LEFT;  duty = drive_speed; end
        dcdw_pkg::MODE_RIGHT: begin pins = dcdw_pkg::PINS_RIGHT; duty = drive_speed; end
        default: ;
      endcase
      r.dir_pins    = pins;
      r.drive_duty  = duty;
      r.fan_duty    = fan;
      r.hand        = hand;
      r.wrist       = wrist;
      r.elbow       = elbow;
      r.base        = base;
      r.claw        = claw;
      r.mode        = mode;
      r.safety_stop = forced;
      expected_outputs.push_back(r);
    endfunction

    function logic [9:0][7:0] field_bytes(drive_outputs_t r);
      return {8'(r.dir_pins), r.drive_duty, r.fan_duty, r.hand, r.wrist, r.elbow,
              r.base, r.claw, 8'(r.mode), 8'(r.safety_stop)};
    endfunction

    // One line per mismatch
    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_outputs(drive_outputs_t got);
      drive_outputs_t  want;
      logic [9:0][7:0] g, w;
      results_seen++;
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                  results_seen));
        return;
      end
      want = expected_outputs.pop_front();
      g = field_bytes(got);
      w = field_bytes(want);
      for (int i = 0; i < 10; i++) begin
        if (g[9-i] !== w[9-i])
          report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                    results_seen, field_names[i], g[9-i], w[9-i]));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        req_type_i  = 1'b0;
  logic [7:0]  cmd_byte_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  dir_pins_o;
  logic [7:0]  drive_duty_o, fan_duty_o;
  logic [7:0]  hand_angle_o, wrist_angle_o, elbow_angle_o, base_angle_o, claw_angle_o;
  logic [2:0]  drive_mode_o;
  logic        safety_stop_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  drive_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  int unsigned     cur_timeout = dcdw_pkg::TIMEOUT_MS_RST;

  drive_command_decoder_watchdog_unit uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .req_type_i, .cmd_byte_i,
    .out_valid_o, .out_ready_i, .dir_pins_o, .drive_duty_o, .fan_duty_o,
    .hand_angle_o, .wrist_angle_o, .elbow_angle_o, .base_angle_o, .claw_angle_o,
    .drive_mode_o, .safety_stop_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("drive_command_decoder_watchdog_unit test failed");
    $finish;
  end

  // Result side: check accepted transactions, stall at random
  always @(posedge clk_i) begin : result_monitor
    drive_outputs_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.dir_pins    = dir_pins_o;
      seen.drive_duty  = drive_duty_o;
      seen.fan_duty    = fan_duty_o;
      seen.hand        = hand_angle_o;
      seen.wrist       = wrist_angle_o;
      seen.elbow       = elbow_angle_o;
      seen.base        = base_angle_o;
      seen.claw        = claw_angle_o;
      seen.mode        = dcdw_pkg::drive_mode_e'(drive_mode_o);
      seen.safety_stop = safety_stop_o;
      sb.check_outputs(seen);
    end
    out_ready_i <= !gaps_on || ($urandom_range(99) >= 12);
  end

  // One input transaction; called right after a rising edge
  task automatic send_item(input logic is_tick, input logic [7:0] cmd);
    if (gaps_on && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= is_tick;
    cmd_byte_i <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_outputs(is_tick, cmd);
  endtask

  // Hold off input until every owed result has been taken
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_outputs.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup then access phase, then back to idle; block must be idle
  task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    sb.write_register(index, value);
  endtask

  task automatic set_timeout(input logic [15:0] limit);
    apb_write(dcdw_pkg::REG_TIMEOUT_MS, {16'($urandom), limit});
    cur_timeout = limit;
  endtask

  // Tick bursts mixed with commands; under a timeout below 40 a burst can outrun it
  task automatic run_phase(input int n_items);
    int sent;
    int burst;
    int kind;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        burst = $urandom_range(1, (cur_timeout < 40) ? cur_timeout + 3 : 20);
        repeat (burst) send_item(1'b1, 8'($urandom));
        sent += burst;
      end else begin
        if (kind < 62)
          send_item(1'b0, COMMAND_SET[$urandom_range(3)]);
        else if (kind < 88)
          send_item(1'b0, COMMAND_SET[$urandom_range(15)]);
        else
          send_item(1'b0, 8'($urandom));
        sent++;
      end
      if (!drained && sent >= n_items / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    int drive_tab [PHASE_COUNT] = '{0, 255, 1, -1, 128, -1, 255, -1, 7};
    int fan_tab   [PHASE_COUNT] = '{0, 255, 128, -1, 0, -1, 1, -1, 254};
    int limit_tab [PHASE_COUNT] = '{0, 1, 3, 10, 65534, 40, 2, -1, 5000};
    int drive_val, fan_val, limit_val;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, field extremes, every command letter, stop holding pins
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'hFF);
    for (int i = 0; i < 16; i++) send_item(1'b0, COMMAND_SET[i]);
    send_item(1'b0, dcdw_pkg::CMD_RIGHT);
    send_item(1'b0, dcdw_pkg::CMD_STOP);
    send_item(1'b1, 8'h5A);
    wait_for_drain();

    // Random phases over several register settings
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drive_val = (drive_tab[p] < 0) ? $urandom_range(255) : drive_tab[p];
      fan_val   = (fan_tab[p] < 0) ? $urandom_range(255) : fan_tab[p];
      limit_val = (limit_tab[p] < 0) ? $urandom_range(30) : limit_tab[p];
      wait_for_drain();
      apb_write(dcdw_pkg::REG_DRIVE_SPEED, {24'($urandom), 8'(drive_val)});
      apb_write(dcdw_pkg::REG_FAN_SPEED, {24'($urandom), 8'(fan_val)});
      set_timeout(16'(limit_val));
      apb_write(REG_SPARE, $urandom);
      // one phase runs with no gaps or stalls at all
      gaps_on = (p != 2);
      run_phase(PHASE_ITEMS);
    end
    gaps_on = 1'b1;

    // Largest timeouts: a run of ticks well short of them never forces a stop
    wait_for_drain();
    set_timeout(dcdw_pkg::IDLE_MAX);
    send_item(1'b0, dcdw_pkg::CMD_LEFT);
    repeat (LONG_TIMEOUT_TICKS) send_item(1'b1, 8'($urandom));
    wait_for_drain();
    set_timeout(dcdw_pkg::IDLE_MAX - 16'd1);
    send_item(1'b1, 8'($urandom));
    send_item(1'b1, 8'($urandom));
    send_item(1'b0, dcdw_pkg::CMD_FWD);
    send_item(1'b1, 8'($urandom));

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (sb.expected_outputs.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.expected_outputs.size()));
    if (sb.mismatches == 0)
      $display("drive_command_decoder_watchdog_unit test passed");
    else
      $display("drive_command_decoder_watchdog_unit test failed");
    $finish;
  end

endmodule
